// ===== design/header_length_trailer_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HLTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked out of reset.
`define HLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== design/hltd_pkg.sv =====
// Types and constants for the header/length/trailer deframer.
package hltd_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] EV_TAKEN   = 2'd0;
  localparam logic [1:0] EV_DONE    = 2'd1;
  localparam logic [1:0] EV_DROP    = 2'd2;
  localparam logic [1:0] EV_IGNORED = 2'd3;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] TRAIL_CR    = 8'h0D;
  localparam logic [7:0] TRAIL_LF    = 8'h0A;

  localparam int unsigned MIN_LEN = 5;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       frame_held;
    logic [7:0] read_data;
  } out_item_t;

endpackage

// ===== design/hltd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hltd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/header_length_trailer_deframer.sv =====
// Top level of the sync-header, length-field, CR/LF-trailer frame receiver.
//
//   channel   ports                         beat payload
//   input     in_valid / in_ready / in_data  in_item_t: op, rx_byte, read_index
//   result    out_valid / out_ready / out_data  out_item_t: event_res, frame_held,
//                                                read_data
//
// One beat is accepted per cycle unless the input stalls (see below); its result is
// registered in the middle stage with the buffer read, then moves to the output register.
// Frame state updates and the buffer write happen at the accept edge itself.
// Reset (rst_n low, synchronous) clears the sync flags, byte count, held flag and
// both pipeline stages; buffer contents are kept and are valid only once written.
// A stalled result holds in the output register; the middle stage keeps filling,
// so input stalls only when both stages are full and out_ready is low.
module header_length_trailer_deframer
  import hltd_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "header_length_trailer_deframer_defines.svh"

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int IW = (AW > 6) ? AW : 6;
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  // frame tracking state
  logic          first_r, first_nxt;
  logic          second_r, second_nxt;
  logic          cr_r, cr_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    len_r;

  // pipeline
  logic       s1_valid_r;
  logic [1:0] s1_ev_r;
  logic       s1_held_r;
  logic       s1_rd_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic          in_acc;
  logic          s1_go;
  logic [1:0]    ev_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    len_cur;
  logic [XW-1:0] cnt_inc_x;
  logic [XW-1:0] len_x;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic [7:0]    ram_q;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  assign cnt_inc   = cnt_r + CW'(1);
  assign len_cur   = (cnt_r == CW'(3)) ? in_data.rx_byte : len_r;
  assign cnt_inc_x = XW'(cnt_inc);
  assign len_x     = XW'(len_cur);

  assign idx_ext     = IW'(in_data.read_index);
  assign rd_addr     = idx_ext[AW-1:0];
  assign rd_in_range = ({1'b0, idx_ext} < (IW + 1)'(BUF_DEPTH));

  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    cr_nxt     = cr_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    ev_nxt     = EV_TAKEN;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    unique case (in_data.op)
      OP_BYTE: begin
        if (done_r) begin
          ev_nxt = EV_IGNORED;
        end else if (second_r) begin
          if (cnt_r >= CW'(BUF_DEPTH)) begin
            first_nxt  = 1'b0;
            second_nxt = 1'b0;
            cr_nxt     = 1'b0;
            cnt_nxt    = '0;
            ev_nxt     = EV_DROP;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_inc;
            if (cr_r) begin
              // trailer LF closes or drops the frame
              first_nxt  = 1'b0;
              second_nxt = 1'b0;
              cr_nxt     = 1'b0;
              cnt_nxt    = '0;
              if (in_data.rx_byte == TRAIL_LF) begin
                done_nxt = 1'b1;
                ev_nxt   = EV_DONE;
              end else begin
                ev_nxt = EV_DROP;
              end
            end else if (cnt_inc >= CW'(4)) begin
              if ((cnt_inc == CW'(4)) &&
                  ((len_x < XW'(MIN_LEN)) || (len_x > XW'(BUF_DEPTH)))) begin
                first_nxt  = 1'b0;
                second_nxt = 1'b0;
                cnt_nxt    = '0;
                ev_nxt     = EV_DROP;
              end else if (cnt_inc_x == len_x - XW'(1)) begin
                if (in_data.rx_byte == TRAIL_CR) begin
                  cr_nxt = 1'b1;
                end else begin
                  first_nxt  = 1'b0;
                  second_nxt = 1'b0;
                  cnt_nxt    = '0;
                  ev_nxt     = EV_DROP;
                end
              end
            end
          end
        end else if (!first_r) begin
          if (in_data.rx_byte == SYNC_FIRST) begin
            wr_en     = 1'b1;
            wr_addr   = AW'(0);
            cnt_nxt   = CW'(1);
            first_nxt = 1'b1;
          end
        end else if (in_data.rx_byte == SYNC_SECOND) begin
          wr_en      = 1'b1;
          wr_addr    = AW'(1);
          cnt_nxt    = CW'(2);
          second_nxt = 1'b1;
        end else if (in_data.rx_byte == SYNC_FIRST) begin
          // restart sync on a repeated first header byte
          wr_en   = 1'b1;
          wr_addr = AW'(0);
          cnt_nxt = CW'(1);
        end else begin
          first_nxt = 1'b0;
          cnt_nxt   = '0;
          ev_nxt    = EV_DROP;
        end
      end
      OP_RELEASE: begin
        done_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b0;
      second_r <= 1'b0;
      cr_r     <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (in_acc) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      cr_r     <= cr_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // shadow of the length byte at buffer index 3
  always_ff @(posedge clk) begin
    if (in_acc && wr_en && second_r && (cnt_r == CW'(3))) begin
      len_r <= in_data.rx_byte;
    end
  end

  hltd_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (in_acc && wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_data.rx_byte),
    .rd_en  (in_acc),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ev_r   <= ev_nxt;
      s1_held_r <= done_nxt;
      s1_rd_r   <= (in_data.op == OP_READ) && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r.event_res  <= s1_ev_r;
      out_data_r.frame_held <= s1_held_r;
      out_data_r.read_data  <= s1_rd_r ? ram_q : 8'h00;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HLTD_ASSERT_IMPL(a_held_no_progress, clk, rst_n, done_r, !first_r && !second_r && !cr_r)
  `HLTD_ASSERT_IMPL(a_sync_order, clk, rst_n, second_r || cr_r, first_r && second_r)
  `HLTD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CW'(BUF_DEPTH))
  `HLTD_ASSERT_IMPL(a_ignored_held, clk, rst_n, out_valid && (out_data.event_res == EV_IGNORED), out_data.frame_held)
  `HLTD_ASSERT_NEXT(a_release_clears, clk, rst_n, in_acc && (in_data.op == OP_RELEASE), !done_r)

endmodule
